### rtl/core/tese_pkg.sv
// tese_pkg: shared types and codes for the tagged entry stack engine
// used by tese_cell and tagged_entry_stack_engine_unit, depends on nothing
package tese_pkg;

    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 8;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 5;
    localparam logic [COUNT_W-1:0] MATCH_RESET = 8'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_SWAP   = 3'd3,
        OP_DUP    = 3'd4,
        OP_REMOVE = 3'd5
    } op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FEW   = 2'd2,
        ST_FULL  = 2'd3
    } status_e;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_DOWN,
        CMD_UP,
        CMD_SWAP,
        CMD_ROT
    } cell_cmd_e;

    typedef enum logic {
        FSM_IDLE,
        FSM_COMPACT
    } fsm_e;

    typedef struct packed {
        cell_cmd_e cmd;
        logic      keep;
        entry_t    rot;
    } cell_ctl_t;

endpackage

### rtl/core/tese_cell.sv
// tese_cell: one stack slot, moves its entry to or from its neighbors
// depends on tese_pkg
module tese_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  tese_pkg::cell_ctl_t ctl,
    input  logic                tail_hit,
    input  tese_pkg::entry_t    above,
    input  tese_pkg::entry_t    below,
    output tese_pkg::entry_t    q
);
    import tese_pkg::*;

    localparam bit IS_TOP    = (CELL_IDX == 0);
    localparam bit IS_SECOND = (CELL_IDX == 1);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.cmd)
            CMD_HOLD: entry_next = entry_reg;
            CMD_DOWN: entry_next = above;
            CMD_UP:   entry_next = below;
            CMD_SWAP:
            begin
                if (IS_TOP)
                    entry_next = below;
                else if (IS_SECOND)
                    entry_next = above;
            end
            CMD_ROT:
            begin
                if (tail_hit && ctl.keep)
                    entry_next = ctl.rot;
                else
                    entry_next = below;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

### rtl/core/tagged_entry_stack_engine_unit.sv
// tagged_entry_stack_engine_unit: bounded lifo of tag/count entries in a row of cells
// depends on tese_pkg and tese_cell
//
// channel  | handshake           | payload
// input    | in_valid/in_ready   | op, in_tag, in_count
// result   | res_valid/res_ready | out_tag, out_count, out_valid, status, fill_level
// config   | cfg_wr_en           | cfg_wr_data (match_count)
//
// push, pop, peek, swap, dup and unused codes give their result in the cycle after they are taken; cell 0 is the top
// remove rotates the live entries through the cell row, one per cycle
// a new beat is taken while the sequencer is idle and the result register is empty or being drained
// reset clears the fill level, the sequencer and the result valid; cells are not cleared
module tagged_entry_stack_engine_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] in_tag,
    input  logic [7:0]  in_count,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [15:0] out_tag,
    output logic [7:0]  out_count,
    output logic        out_valid,
    output logic [1:0]  status,
    output logic [4:0]  fill_level,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import tese_pkg::*;

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(STACK_DEPTH);
    localparam logic [FILL_W-1:0] ONE = FILL_W'(1);
    localparam logic [FILL_W-1:0] TWO = FILL_W'(2);

    fsm_e                state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   live_reg, live_next;
    logic [FILL_W-1:0]   left_reg, left_next;
    logic [COUNT_W-1:0]  match_reg;
    logic                res_valid_reg, res_valid_next;
    entry_t              res_entry_reg, res_entry_next;
    logic                res_has_reg, res_has_next;
    status_e             res_status_reg, res_status_next;
    logic [FILL_W-1:0]   res_fill_reg, res_fill_next;

    cell_ctl_t            cell_ctl;
    entry_t               top_in;
    entry_t               cell_q [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] tail_hit;
    logic                 accept;
    logic [FILL_W-1:0]    tail_level;
    logic [31:0]          fill_wide;

    assign in_ready = (state_reg == FSM_IDLE) && (!res_valid_reg || res_ready);
    assign accept   = in_valid && in_ready;
    assign top_in   = (op_e'(op) == OP_DUP) ? cell_q[0] : entry_t'({in_tag, in_count});
    assign tail_level = live_reg - ONE;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        entry_t above;
        entry_t below;
        if (i == 0)
        begin : g_top
            assign above = top_in;
        end
        else
        begin : g_mid
            assign above = cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_end
            assign below = cell_q[i];
        end
        else
        begin : g_link
            assign below = cell_q[i+1];
        end
        assign tail_hit[i] = (tail_level == FILL_W'(i));
        tese_cell #(
            .CELL_IDX(i)
        ) u_cell (
            .clk     (clk),
            .ctl     (cell_ctl),
            .tail_hit(tail_hit[i]),
            .above   (above),
            .below   (below),
            .q       (cell_q[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        live_next       = live_reg;
        left_next       = left_reg;
        res_entry_next  = res_entry_reg;
        res_has_next    = res_has_reg;
        res_status_next = res_status_reg;
        res_fill_next   = res_fill_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        cell_ctl.cmd    = CMD_HOLD;
        cell_ctl.keep   = (cell_q[0].count != match_reg);
        cell_ctl.rot    = cell_q[0];

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    res_valid_next  = 1'b1;
                    res_entry_next  = '0;
                    res_has_next    = 1'b0;
                    res_status_next = ST_OK;
                    unique case (op_e'(op))
                        OP_PUSH:
                        begin
                            if (fill_reg >= FULL_LEVEL)
                                res_status_next = ST_FULL;
                            else
                            begin
                                cell_ctl.cmd = CMD_DOWN;
                                fill_next    = fill_reg + ONE;
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (fill_reg == '0)
                                res_status_next = ST_EMPTY;
                            else
                            begin
                                res_entry_next = cell_q[0];
                                res_has_next   = 1'b1;
                                if (op_e'(op) == OP_POP)
                                begin
                                    cell_ctl.cmd = CMD_UP;
                                    fill_next    = fill_reg - ONE;
                                end
                            end
                        end
                        OP_SWAP:
                        begin
                            if (fill_reg < TWO)
                                res_status_next = ST_FEW;
                            else
                                cell_ctl.cmd = CMD_SWAP;
                        end
                        OP_DUP:
                        begin
                            if (fill_reg == '0)
                                res_status_next = ST_EMPTY;
                            else if (fill_reg >= FULL_LEVEL)
                                res_status_next = ST_FULL;
                            else
                            begin
                                cell_ctl.cmd = CMD_DOWN;
                                fill_next    = fill_reg + ONE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (fill_reg == '0)
                                res_status_next = ST_EMPTY;
                            else
                            begin
                                res_valid_next = 1'b0;
                                live_next      = fill_reg;
                                left_next      = fill_reg;
                                state_next     = FSM_COMPACT;
                            end
                        end
                        default: ;
                    endcase
                    res_fill_next = fill_next;
                end
            end
            FSM_COMPACT:
            begin
                cell_ctl.cmd = CMD_ROT;
                live_next    = cell_ctl.keep ? live_reg : live_reg - ONE;
                left_next    = left_reg - ONE;
                if (left_reg == ONE)
                begin
                    state_next     = FSM_IDLE;
                    fill_next      = live_next;
                    res_valid_next = 1'b1;
                    res_fill_next  = live_next;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            fill_reg      <= '0;
            match_reg     <= MATCH_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
                match_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        live_reg       <= live_next;
        left_reg       <= left_next;
        res_entry_reg  <= res_entry_next;
        res_has_reg    <= res_has_next;
        res_status_reg <= res_status_next;
        res_fill_reg   <= res_fill_next;
    end

    assign fill_wide  = 32'(res_fill_reg);
    assign res_valid  = res_valid_reg;
    assign out_tag    = res_entry_reg.tag;
    assign out_count  = res_entry_reg.count;
    assign out_valid  = res_has_reg;
    assign status     = res_status_reg;
    assign fill_level = fill_wide[4:0];

    a_no_take_in_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_COMPACT) |-> !in_ready)
        else $error("beat taken during compaction");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_LEVEL)
        else $error("fill level beyond depth");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_e'(op) != OP_REMOVE)) |=> res_valid)
        else $error("no result after single cycle op");

    a_live_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_COMPACT) |-> (live_reg <= fill_reg && live_reg >= left_reg))
        else $error("compaction count out of range");

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for tagged_entry_stack_engine_unit
// keeps its own stack model and checks every result beat against it
// depends on tese_pkg and the rtl of tagged_entry_stack_engine_unit
module tb_top;
    import tese_pkg::*;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 100;
    localparam logic [OP_W-1:0] OP_NONE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE_7 = 3'd7;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
        logic               valid;
        status_e            status;
        logic [LEVEL_W-1:0] level;
    } stack_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op = '0;
    logic [TAG_W-1:0]    in_tag = '0;
    logic [COUNT_W-1:0]  in_count = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [TAG_W-1:0]    out_tag;
    logic [COUNT_W-1:0]  out_count;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [LEVEL_W-1:0]  fill_level;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;

    logic [TAG_W-1:0]   stack_tags [DEPTH];
    logic [COUNT_W-1:0] stack_counts [DEPTH];
    int                 stack_fill = 0;
    logic [COUNT_W-1:0] match_value = MATCH_RESET;
    stack_result_t      pending_results [$];

    int          error_count = 0;
    int          result_beats = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          sender_gaps = 1'b1;
    logic [9:0]  stall_phase = '0;

    tagged_entry_stack_engine_unit #(.STACK_DEPTH(DEPTH)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .in_tag      (in_tag),
        .in_count    (in_count),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_tag     (out_tag),
        .out_count   (out_count),
        .out_valid   (out_valid),
        .status      (status),
        .fill_level  (fill_level),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic stack_result_t predict_stack_op(logic [OP_W-1:0] code,
                                                       logic [TAG_W-1:0] tag,
                                                       logic [COUNT_W-1:0] cnt);
        stack_result_t      res;
        logic [TAG_W-1:0]   tmp_tag;
        logic [COUNT_W-1:0] tmp_count;
        int                 kept;
        res = '0;
        res.status = ST_OK;
        case (code)
            OP_PUSH:
            begin
                if (stack_fill >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    stack_tags[stack_fill] = tag;
                    stack_counts[stack_fill] = cnt;
                    stack_fill++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (stack_fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.tag = stack_tags[stack_fill-1];
                    res.count = stack_counts[stack_fill-1];
                    res.valid = 1'b1;
                    if (code == OP_POP)
                        stack_fill--;
                end
            end
            OP_SWAP:
            begin
                if (stack_fill < 2)
                    res.status = ST_FEW;
                else
                begin
                    tmp_tag = stack_tags[stack_fill-1];
                    tmp_count = stack_counts[stack_fill-1];
                    stack_tags[stack_fill-1] = stack_tags[stack_fill-2];
                    stack_counts[stack_fill-1] = stack_counts[stack_fill-2];
                    stack_tags[stack_fill-2] = tmp_tag;
                    stack_counts[stack_fill-2] = tmp_count;
                end
            end
            OP_DUP:
            begin
                if (stack_fill == 0)
                    res.status = ST_EMPTY;
                else if (stack_fill >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    stack_tags[stack_fill] = stack_tags[stack_fill-1];
                    stack_counts[stack_fill] = stack_counts[stack_fill-1];
                    stack_fill++;
                end
            end
            OP_REMOVE:
            begin
                if (stack_fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    kept = 0;
                    for (int r = 0; r < stack_fill; r++)
                    begin
                        if (stack_counts[r] != match_value)
                        begin
                            stack_tags[kept] = stack_tags[r];
                            stack_counts[kept] = stack_counts[r];
                            kept++;
                        end
                    end
                    stack_fill = kept;
                end
            end
            default:
            begin
            end
        endcase
        res.level = stack_fill[LEVEL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch %s at result beat %0d: expected %0h got %0h",
                     field, result_beats, want, got);
    endtask

    // model update, result check and watchdog share one edge process
    always @(posedge clk)
    begin : result_check
        stack_result_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                match_value = cfg_wr_data;
            if (in_valid && in_ready)
                pending_results.push_back(predict_stack_op(op, in_tag, in_count));
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat", 32'd0, 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_tag !== want.tag)
                        report_mismatch("out_tag", 32'(want.tag), 32'(out_tag));
                    if (out_count !== want.count)
                        report_mismatch("out_count", 32'(want.count), 32'(out_count));
                    if (out_valid !== want.valid)
                        report_mismatch("out_valid", 32'(want.valid), 32'(out_valid));
                    if (status !== want.status)
                        report_mismatch("status", 32'(want.status), 32'(status));
                    if (fill_level !== want.level)
                        report_mismatch("fill_level", 32'(want.level), 32'(fill_level));
                end
                result_beats++;
            end
            if ((in_valid || pending_results.size() != 0) &&
                !((in_valid && in_ready) || (res_valid && res_ready)))
                idle_cycles++;
            else
                idle_cycles = 0;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver back-pressure, cycling through four modes picked by stall_phase[8:7]
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[8:7])
            2'd0: res_ready <= 1'b1;
            2'd1: res_ready <= 1'($urandom_range(0, 1));
            2'd2: res_ready <= (stall_phase[1:0] == 2'd0);
            default: res_ready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    task automatic send_beat(logic [OP_W-1:0] code, logic [TAG_W-1:0] tag,
                             logic [COUNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= code;
        in_tag <= tag;
        in_count <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);
    endtask

    task automatic set_match(logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_empty_ops();
        send_beat(OP_POP, 16'hFFFF, 8'hFF);
        send_beat(OP_PEEK, 16'h0000, 8'h00);
        send_beat(OP_SWAP, 16'hAAAA, 8'h55);
        send_beat(OP_DUP, 16'h5555, 8'hAA);
        send_beat(OP_REMOVE, 16'h0000, 8'h02);
        send_beat(OP_NONE_6, 16'hFFFF, 8'hFF);
        send_beat(OP_NONE_7, 16'h1234, 8'h56);
    endtask

    task automatic test_top_ops();
        send_beat(OP_PUSH, 16'hFFFF, 8'hFF);
        send_beat(OP_SWAP, 16'h0000, 8'h00);
        send_beat(OP_PEEK, 16'h0000, 8'h00);
        send_beat(OP_PUSH, 16'h0000, 8'h00);
        send_beat(OP_SWAP, 16'h0000, 8'h00);
        send_beat(OP_PUSH, 16'h1234, MATCH_RESET);
        send_beat(OP_DUP, 16'h0000, 8'h00);
        send_beat(OP_REMOVE, 16'h0000, 8'h00);
        send_beat(OP_POP, 16'h0000, 8'h00);
        send_beat(OP_POP, 16'h0000, 8'h00);
        send_beat(OP_POP, 16'h0000, 8'h00);
    endtask

    task automatic test_full_stack();
        set_match(8'h5A);
        for (int i = 0; i < 4; i++)
            send_beat(OP_PUSH, 16'(16'hC000 + i), (i % 2 == 0) ? 8'h5A : 8'hA5);
        for (int i = 0; i < 12; i++)
            send_beat(OP_DUP, 16'h0000, 8'h00);
        send_beat(OP_PUSH, 16'hBEEF, 8'h01);
        send_beat(OP_DUP, 16'h0000, 8'h00);
        send_beat(OP_SWAP, 16'h0000, 8'h00);
        send_beat(OP_REMOVE, 16'h0000, 8'h00);
        send_beat(OP_PEEK, 16'h0000, 8'h00);
    endtask

    task automatic test_random_phase(logic [COUNT_W-1:0] match, int beats, int push_weight,
                                     bit gaps);
        logic [OP_W-1:0]    code;
        logic [COUNT_W-1:0] cnt;
        int                 sent;
        int                 pick;
        set_match(match);
        sender_gaps = gaps;
        sent = 0;
        while (sent < beats)
        begin
            if ($urandom_range(0, 99) < push_weight)
                code = OP_PUSH;
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 6)
                    code = OP_POP;
                else if (pick < 9)
                    code = OP_PEEK;
                else if (pick < 12)
                    code = OP_SWAP;
                else if (pick < 16)
                    code = OP_DUP;
                else if (pick < 18)
                    code = OP_REMOVE;
                else if (pick == 18)
                    code = OP_NONE_6;
                else
                    code = OP_NONE_7;
            end
            case ($urandom_range(0, 3))
                0: cnt = match;
                1: cnt = match ^ 8'h01;
                2: cnt = 8'($urandom_range(0, 255));
                default: cnt = 8'($urandom_range(0, 3));
            endcase
            send_beat(code, 16'($urandom_range(0, 65535)), cnt);
            sent++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_ops();
        test_top_ops();
        test_full_stack();
        test_random_phase(8'h00, 100, 30, 1'b1);
        test_random_phase(8'hFF, 100, 60, 1'b1);
        test_random_phase(8'($urandom_range(0, 255)), 100, 45, 1'b0);
        test_random_phase(MATCH_RESET, 100, 20, 1'b1);
        test_random_phase(8'($urandom_range(0, 255)), 100, 50, 1'b1);
        wait_idle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
